/* rtl/core/grid_neighbor_enumeration_macros.svh */
// assertion macros for the grid neighbor enumeration block
`ifndef GRID_NEIGHBOR_ENUMERATION_MACROS_SVH
`define GRID_NEIGHBOR_ENUMERATION_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GNE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GNE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/gne_pkg.sv */
// shared widths and register indexes for the grid neighbor enumeration block
package gne_pkg;

    localparam int NUM_DIMS = 3;
    localparam int CENTER_W = 10;
    localparam int BINS_W   = 11;
    localparam int MASK_W   = 3;
    localparam int DIMS_W   = 2;
    localparam int INDEX_W  = 30;
    localparam int INNER_W  = CENTER_W + BINS_W - 1;
    localparam int PROD_W   = BINS_W + INNER_W;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REGIDX_W = ADDR_W - 2;

    localparam logic [REGIDX_W-1:0] REG_BINS_DIM0     = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_BINS_DIM1     = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_BINS_DIM2     = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_PERIODIC_MASK = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_DIMS_IN_USE   = 3'd4;

endpackage

/* rtl/core/gne_stream_if.sv */
// request and result stream interfaces for the grid neighbor enumeration block
interface gne_req_if
    import gne_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CENTER_W-1:0] center_dim0;
    logic [CENTER_W-1:0] center_dim1;
    logic [CENTER_W-1:0] center_dim2;
    logic                reach_dim0;
    logic                reach_dim1;
    logic                reach_dim2;

    modport source (
        output valid, center_dim0, center_dim1, center_dim2,
               reach_dim0, reach_dim1, reach_dim2,
        input  ready
    );
    modport sink (
        input  valid, center_dim0, center_dim1, center_dim2,
               reach_dim0, reach_dim1, reach_dim2,
        output ready
    );
endinterface

interface gne_rsp_if
    import gne_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] neighbor_index;
    logic               last;
    logic               empty_res;

    modport source (
        output valid, neighbor_index, last, empty_res,
        input  ready
    );
    modport sink (
        input  valid, neighbor_index, last, empty_res,
        output ready
    );
endinterface

/* rtl/core/grid_neighbor_enumeration.sv */
// grid neighbor enumeration top level
//
// req carries a center cell and a reach (0 or 1) per dimension; one transfer
// starts one request. rsp returns the column-major flat index of every kept
// neighbor cell, dimension zero varying fastest, with last on the final one.
// when no cell is kept a single result with empty_res and last is returned.
// the apb port holds bins per dimension, the periodic mask and dims in use;
// write it only while no request is in flight.
// order: after the req transfer a remainder phase runs in the single
// bit-serial remainder unit, bit by bit for an active periodic dimension,
// passing the center straight through for any other. each candidate is then
// checked in S_CAND: a dropped one moves on, a kept one runs S_MUL1, S_MUL2
// and S_PUSH, the shared multiplier being used twice per kept cell. S_IDLE
// then returns the last result; req is ready only between requests.
// a stalled rsp holds the result register and halts the walk once a second
// kept cell is waiting; a new request may be taken while the last result of
// the previous one still waits. reset returns the sequencer to idle, drops
// any waiting result and loads the register reset values.
module grid_neighbor_enumeration
    import gne_pkg::*;
#(
    parameter int MAX_DIMS  = 3,
    parameter int BIN_LIMIT = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    gne_req_if.sink           req,
    gne_rsp_if.source         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

`include "grid_neighbor_enumeration_macros.svh"

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MOD  = 6'b000010,
        S_CAND = 6'b000100,
        S_MUL1 = 6'b001000,
        S_MUL2 = 6'b010000,
        S_PUSH = 6'b100000
    } walk_state_t;

    typedef enum logic [0:0] {
        F_RUN = 1'b0,
        F_END = 1'b1
    } fin_flag_t;

    localparam logic [3:0] BIT_TOP = 4'(CENTER_W - 1);

    // configuration registers
    logic [BINS_W-1:0] bins0_reg, bins1_reg, bins2_reg;
    logic [MASK_W-1:0] periodic_mask_reg;
    logic [DIMS_W-1:0] dims_in_use_reg;

    // sequencer and payload registers
    walk_state_t         state_reg, state_next;
    fin_flag_t           fin_reg, fin_next;
    logic [1:0]          dim_reg, dim_next;
    logic [3:0]          bit_reg, bit_next;
    logic [CENTER_W-1:0] rem_reg, rem_next;
    logic [CENTER_W-1:0] ctr_reg [NUM_DIMS], ctr_next [NUM_DIMS];
    logic [CENTER_W-1:0] base_reg [NUM_DIMS], base_next [NUM_DIMS];
    logic [BINS_W-1:0]   b_reg [NUM_DIMS], b_next [NUM_DIMS];
    logic [1:0]          o_reg [NUM_DIMS], o_next [NUM_DIMS];
    logic [CENTER_W-1:0] t_reg [NUM_DIMS], t_next [NUM_DIMS];
    logic [NUM_DIMS-1:0] r_reg, r_next;
    logic [NUM_DIMS-1:0] per_reg, per_next;
    logic [INNER_W-1:0]  inner_reg, inner_next;
    logic [INDEX_W-1:0]  flat_reg, flat_next;
    logic [INDEX_W-1:0]  pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]  out_index_reg, out_index_next;
    logic                out_last_reg, out_last_next;
    logic                out_empty_reg, out_empty_next;

    // combinational helpers
    logic [CENTER_W-1:0] center_in [NUM_DIMS];
    logic [NUM_DIMS-1:0] reach_in;
    logic [BINS_W-1:0]   bins_cfg [NUM_DIMS];
    logic [DIMS_W-1:0]   nd;
    logic [BINS_W-1:0]   mod_shift, mod_diff;
    logic [CENTER_W-1:0] cand_t [NUM_DIMS];
    logic                cand_keep;
    logic                cand_last;
    logic [1:0]          o_adv [NUM_DIMS];
    logic [BINS_W-1:0]   mul_a;
    logic [INNER_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_prod;
    logic                out_free;
    logic                cfg_write;

    assign center_in[0] = req.center_dim0;
    assign center_in[1] = req.center_dim1;
    assign center_in[2] = req.center_dim2;
    assign reach_in     = {req.reach_dim2, req.reach_dim1, req.reach_dim0};
    assign bins_cfg[0]  = bins0_reg;
    assign bins_cfg[1]  = bins1_reg;
    assign bins_cfg[2]  = bins2_reg;

    // apb register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins0_reg         <= BINS_W'(1);
            bins1_reg         <= BINS_W'(1);
            bins2_reg         <= BINS_W'(1);
            periodic_mask_reg <= '0;
            dims_in_use_reg   <= DIMS_W'(1);
        end
        else if (cfg_write)
        begin
            case (paddr[ADDR_W-1:2])
                REG_BINS_DIM0:     bins0_reg         <= pwdata[BINS_W-1:0];
                REG_BINS_DIM1:     bins1_reg         <= pwdata[BINS_W-1:0];
                REG_BINS_DIM2:     bins2_reg         <= pwdata[BINS_W-1:0];
                REG_PERIODIC_MASK: periodic_mask_reg <= pwdata[MASK_W-1:0];
                REG_DIMS_IN_USE:   dims_in_use_reg   <= pwdata[DIMS_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[ADDR_W-1:2])
            REG_BINS_DIM0:     prdata = DATA_W'(bins0_reg);
            REG_BINS_DIM1:     prdata = DATA_W'(bins1_reg);
            REG_BINS_DIM2:     prdata = DATA_W'(bins2_reg);
            REG_PERIODIC_MASK: prdata = DATA_W'(periodic_mask_reg);
            REG_DIMS_IN_USE:   prdata = DATA_W'(dims_in_use_reg);
            default:           prdata = '0;
        endcase
    end

    // active dimension count
    always_comb
    begin
        if (dims_in_use_reg == '0)
            nd = DIMS_W'(1);
        else if (dims_in_use_reg > DIMS_W'(MAX_DIMS))
            nd = DIMS_W'(MAX_DIMS);
        else
            nd = dims_in_use_reg;
    end

    // bit-serial remainder step
    assign mod_shift = {rem_reg, ctr_reg[dim_reg][bit_reg]};
    assign mod_diff  = mod_shift - b_reg[dim_reg];

    // candidate coordinates
    always_comb
    begin
        logic [BINS_W:0] v;
        logic [BINS_W:0] bx;
        logic [BINS_W:0] vw;
        cand_keep = 1'b1;
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            bx = {1'b0, b_reg[d]};
            v  = {2'b00, base_reg[d]} + {{(BINS_W-1){1'b0}}, o_reg[d]}
                 - {{BINS_W{1'b0}}, r_reg[d]};
            vw = v;
            if (per_reg[d])
            begin
                if (v[BINS_W])
                    vw = v + bx;
                else if (v >= bx)
                    vw = v - bx;
            end
            else if (v[BINS_W] || v >= bx)
            begin
                cand_keep = 1'b0;
            end
            cand_t[d] = vw[CENTER_W-1:0];
        end
    end

    // offset walk, dimension zero fastest
    always_comb
    begin
        logic carry;
        carry     = 1'b1;
        cand_last = 1'b1;
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            o_adv[d] = o_reg[d];
            if (o_reg[d] != {r_reg[d], 1'b0})
                cand_last = 1'b0;
            if (carry)
            begin
                if (o_reg[d] == {r_reg[d], 1'b0})
                    o_adv[d] = 2'd0;
                else
                begin
                    o_adv[d] = o_reg[d] + 2'd1;
                    carry    = 1'b0;
                end
            end
        end
    end

    // shared multiplier
    assign mul_a    = (state_reg == S_MUL2) ? b_reg[0] : b_reg[1];
    assign mul_b    = (state_reg == S_MUL2) ? inner_reg : INNER_W'(t_reg[2]);
    assign mul_prod = mul_a * mul_b;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && (fin_reg == F_RUN);

    assign rsp.valid          = out_valid_reg;
    assign rsp.neighbor_index = out_index_reg;
    assign rsp.last           = out_last_reg;
    assign rsp.empty_res      = out_empty_reg;

    always_comb
    begin
        state_next      = state_reg;
        fin_next        = fin_reg;
        dim_next        = dim_reg;
        bit_next        = bit_reg;
        rem_next        = rem_reg;
        ctr_next        = ctr_reg;
        base_next       = base_reg;
        b_next          = b_reg;
        o_next          = o_reg;
        t_next          = t_reg;
        r_next          = r_reg;
        per_next        = per_reg;
        inner_next      = inner_reg;
        flat_next       = flat_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_index_next  = out_index_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (fin_reg == F_END)
                begin
                    // closing result of the request
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_last_next   = 1'b1;
                        out_empty_next  = !pend_valid_reg;
                        out_index_next  = pend_valid_reg ? pend_reg : '0;
                        pend_valid_next = 1'b0;
                        fin_next        = F_RUN;
                    end
                end
                else if (req.valid)
                begin
                    for (int d = 0; d < NUM_DIMS; d++)
                    begin
                        if (2'(d) < nd)
                        begin
                            ctr_next[d] = center_in[d];
                            r_next[d]   = reach_in[d];
                            per_next[d] = periodic_mask_reg[d];
                            if (bins_cfg[d] == '0)
                                b_next[d] = BINS_W'(1);
                            else if (bins_cfg[d] > BINS_W'(BIN_LIMIT))
                                b_next[d] = BINS_W'(BIN_LIMIT);
                            else
                                b_next[d] = bins_cfg[d];
                        end
                        else
                        begin
                            ctr_next[d] = '0;
                            r_next[d]   = 1'b0;
                            per_next[d] = 1'b0;
                            b_next[d]   = BINS_W'(1);
                        end
                        o_next[d] = 2'd0;
                    end
                    dim_next        = 2'd0;
                    bit_next        = BIT_TOP;
                    rem_next        = '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_MOD;
                end
            end
            S_MOD:
            begin
                if (!per_reg[dim_reg])
                begin
                    base_next[dim_reg] = ctr_reg[dim_reg];
                    dim_next           = dim_reg + 2'd1;
                    if (dim_reg == 2'(NUM_DIMS - 1))
                        state_next = S_CAND;
                end
                else
                begin
                    rem_next = (mod_shift >= b_reg[dim_reg]) ? mod_diff[CENTER_W-1:0]
                                                             : mod_shift[CENTER_W-1:0];
                    bit_next = bit_reg - 4'd1;
                    if (bit_reg == 4'd0)
                    begin
                        base_next[dim_reg] = rem_next;
                        rem_next           = '0;
                        bit_next           = BIT_TOP;
                        dim_next           = dim_reg + 2'd1;
                        if (dim_reg == 2'(NUM_DIMS - 1))
                            state_next = S_CAND;
                    end
                end
            end
            S_CAND:
            begin
                if (cand_keep)
                begin
                    t_next     = cand_t;
                    state_next = S_MUL1;
                end
                else if (cand_last)
                begin
                    fin_next   = F_END;
                    state_next = S_IDLE;
                end
                else
                begin
                    o_next = o_adv;
                end
            end
            S_MUL1:
            begin
                inner_next = INNER_W'(mul_prod + PROD_W'(t_reg[1]));
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                flat_next  = INDEX_W'(mul_prod + PROD_W'(t_reg[0]));
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_index_next = pend_reg;
                        out_last_next  = 1'b0;
                        out_empty_next = 1'b0;
                    end
                    pend_next       = flat_reg;
                    pend_valid_next = 1'b1;
                    if (cand_last)
                    begin
                        fin_next   = F_END;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        o_next     = o_adv;
                        state_next = S_CAND;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fin_reg        <= F_RUN;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fin_reg        <= fin_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dim_reg       <= dim_next;
        bit_reg       <= bit_next;
        rem_reg       <= rem_next;
        ctr_reg       <= ctr_next;
        base_reg      <= base_next;
        b_reg         <= b_next;
        o_reg         <= o_next;
        t_reg         <= t_next;
        r_reg         <= r_next;
        per_reg       <= per_next;
        inner_reg     <= inner_next;
        flat_reg      <= flat_next;
        pend_reg      <= pend_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    `GNE_ASSERT_NEXT(a_start_mod, req.valid && req.ready, state_reg == S_MOD,
        "request transfer did not start the remainder phase")

    `GNE_ASSERT_NOW(a_coord_range, state_reg == S_MUL1,
        (t_reg[0] < b_reg[0]) && (t_reg[1] < b_reg[1]) && (t_reg[2] < b_reg[2]),
        "kept coordinate outside the grid")

    `GNE_ASSERT_NOW(a_empty_form, out_valid_reg && out_empty_reg,
        out_last_reg && (out_index_reg == '0),
        "empty result without last or with nonzero index")

    `GNE_ASSERT_NEXT(a_empty_on_none,
        (state_reg == S_IDLE) && (fin_reg == F_END) && out_free && !pend_valid_reg,
        out_valid_reg && out_empty_reg,
        "request with no kept cell gave no empty result")

endmodule
